// File: design/video_line_wavetable_sampler_top_macros.svh
// Assertion macros for the video line wavetable sampler.
`ifndef VIDEO_LINE_WAVETABLE_SAMPLER_TOP_MACROS_SVH
`define VIDEO_LINE_WAVETABLE_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define VLWS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vlws: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define VLWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vlws: next-cycle check failed");
`else
`define VLWS_ASSERT_NOW(label, clk, rst, ante, cons)
`define VLWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/vlws_pkg.sv
// Package: types, constants and the sine table of the wavetable sampler.
`timescale 1ns / 1ps
package vlws_pkg;

  // Table depth, a power of two from 16 to 1024.
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LINE_W      = 10;
  localparam int SAMPLE_W    = 10;
  localparam int PERIOD_W    = 15;
  localparam int DELAY_W     = 8;
  localparam int DAC_W       = 8;
  localparam int CFG_DATA_W  = 10;

  localparam logic [LINE_W-1:0]   LINE_MAX     = 10'd1023;
  localparam logic [LINE_W:0]     PERIOD_BASE  = 11'd1044;  // 1024 + 20
  localparam logic [DELAY_W-1:0]  DELAY_OFFSET = 8'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'h00df;
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 8'd150;
  localparam logic [LINE_W-1:0]   REC_START_RESET = 10'd36;
  localparam logic [LINE_W-1:0]   RATE_LINE_RESET = 10'd50;
  localparam logic [LINE_W-1:0]   POS_LINE_RESET  = 10'd120;

  typedef enum logic [1:0] {
    CMD_FIELD_START = 2'd0,
    CMD_LINE_SYNC   = 2'd1,
    CMD_CONV_DONE   = 2'd2,
    CMD_PLAY_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_RECORD_START  = 2'd0,
    CFG_RATE_LINE     = 2'd1,
    CFG_POSITION_LINE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    CHAN_VIDEO    = 2'd0,
    CHAN_RATE     = 2'd1,
    CHAN_POSITION = 2'd2
  } chan_t;

  // Table access for one item: at most one read and one write.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DAC_W-1:0]  wr_data;
  } table_req_t;

  localparam logic [7:0] SINE_ROM [256] = '{
    8'h80,8'h83,8'h86,8'h89,8'h8c,8'h8f,8'h92,8'h95,8'h98,8'h9b,8'h9e,8'ha2,8'ha5,8'ha7,8'haa,8'had,
    8'hb0,8'hb3,8'hb6,8'hb9,8'hbc,8'hbe,8'hc1,8'hc4,8'hc6,8'hc9,8'hcb,8'hce,8'hd0,8'hd3,8'hd5,8'hd7,
    8'hda,8'hdc,8'hde,8'he0,8'he2,8'he4,8'he6,8'he8,8'hea,8'heb,8'hed,8'hee,8'hf0,8'hf1,8'hf3,8'hf4,
    8'hf5,8'hf6,8'hf8,8'hf9,8'hfa,8'hfa,8'hfb,8'hfc,8'hfd,8'hfd,8'hfe,8'hfe,8'hfe,8'hff,8'hff,8'hff,
    8'hff,8'hff,8'hff,8'hff,8'hfe,8'hfe,8'hfe,8'hfd,8'hfd,8'hfc,8'hfb,8'hfa,8'hfa,8'hf9,8'hf8,8'hf6,
    8'hf5,8'hf4,8'hf3,8'hf1,8'hf0,8'hee,8'hed,8'heb,8'hea,8'he8,8'he6,8'he4,8'he2,8'he0,8'hde,8'hdc,
    8'hda,8'hd7,8'hd5,8'hd3,8'hd0,8'hce,8'hcb,8'hc9,8'hc6,8'hc4,8'hc1,8'hbe,8'hbc,8'hb9,8'hb6,8'hb3,
    8'hb0,8'had,8'haa,8'ha7,8'ha5,8'ha2,8'h9e,8'h9b,8'h98,8'h95,8'h92,8'h8f,8'h8c,8'h89,8'h86,8'h83,
    8'h80,8'h7c,8'h79,8'h76,8'h73,8'h70,8'h6d,8'h6a,8'h67,8'h64,8'h61,8'h5d,8'h5a,8'h58,8'h55,8'h52,
    8'h4f,8'h4c,8'h49,8'h46,8'h43,8'h41,8'h3e,8'h3b,8'h39,8'h36,8'h34,8'h31,8'h2f,8'h2c,8'h2a,8'h28,
    8'h25,8'h23,8'h21,8'h1f,8'h1d,8'h1b,8'h19,8'h17,8'h15,8'h14,8'h12,8'h11,8'h0f,8'h0e,8'h0c,8'h0b,
    8'h0a,8'h09,8'h07,8'h06,8'h05,8'h05,8'h04,8'h03,8'h02,8'h02,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h02,8'h02,8'h03,8'h04,8'h05,8'h05,8'h06,8'h07,8'h09,
    8'h0a,8'h0b,8'h0c,8'h0e,8'h0f,8'h11,8'h12,8'h14,8'h15,8'h17,8'h19,8'h1b,8'h1d,8'h1f,8'h21,8'h23,
    8'h25,8'h28,8'h2a,8'h2c,8'h2f,8'h31,8'h34,8'h36,8'h39,8'h3b,8'h3e,8'h41,8'h43,8'h46,8'h49,8'h4c,
    8'h4f,8'h52,8'h55,8'h58,8'h5a,8'h5d,8'h61,8'h64,8'h67,8'h6a,8'h6d,8'h70,8'h73,8'h76,8'h79,8'h7c
  };

  // Reset content of a table entry: the sine stretched over the table depth.
  function automatic logic [7:0] table_init(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W+7:0] scaled;
    scaled = (ADDR_W + 8)'({idx, 8'd0} / TABLE_DEPTH);
    return SINE_ROM[scaled[7:0]];
  endfunction

endpackage

// File: design/vlws_in_if.sv
// Input item channel: command and pin levels of one event.
`timescale 1ns / 1ps
interface vlws_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic                          field_odd;
  logic                          rec_pin;
  logic                          fast_pin;
  logic                          osc_pin;
  logic [vlws_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, command, field_odd, rec_pin, fast_pin, osc_pin, sample,
                  input ready);
  modport sink   (input valid, command, field_odd, rec_pin, fast_pin, osc_pin, sample,
                  output ready);
endinterface

// File: design/vlws_out_if.sv
// Result item channel: output converter value and current settings.
`timescale 1ns / 1ps
interface vlws_out_if;
  logic                          valid;
  logic                          ready;
  logic                          dac_write;
  logic [vlws_pkg::DAC_W-1:0]    dac_value;
  logic [vlws_pkg::PERIOD_W-1:0] playback_period;
  logic                          playback_running;
  logic [vlws_pkg::DELAY_W-1:0]  pulse_delay;
  logic [1:0]                    adc_channel;

  modport source (output valid, dac_write, dac_value, playback_period, playback_running,
                  pulse_delay, adc_channel, input ready);
  modport sink   (input valid, dac_write, dac_value, playback_period, playback_running,
                  pulse_delay, adc_channel, output ready);
endinterface

// File: design/video_line_wavetable_sampler_top.sv
// Top level of the video line wavetable sampler.
//
//  port        | dir  | handshake         | carries
//  ------------+------+-------------------+---------------------------------------------
//  items       | in   | valid/ready       | command, field_odd, pins, 10-bit sample
//  results     | out  | valid/ready       | dac_write/value, period, running, delay, chan
//  cfg_*       | in   | cfg_we, no stall  | record start, rate line, position line
//
//  One item per cycle: out of reset, an item is taken whenever the result register is
//  empty or being drained, so the result register is the only stage between the sides.
//  The table read is a registered memory read issued with the item; the result
//  shows it in the cycle after acceptance, together with the other result fields.
//  Reset (rst, synchronous) restores the sine table at once through per-entry
//  written bits; no clearing pass. A stalled result holds all fields.
`timescale 1ns / 1ps
`include "video_line_wavetable_sampler_top_macros.svh"
module video_line_wavetable_sampler_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [vlws_pkg::CFG_DATA_W-1:0]   cfg_data,
  vlws_in_if.sink                           items,
  vlws_out_if.source                        results
);

  // configuration registers
  logic [vlws_pkg::LINE_W-1:0] record_start_line;
  logic [vlws_pkg::LINE_W-1:0] rate_line;
  logic [vlws_pkg::LINE_W-1:0] position_line;

  // block state
  logic [vlws_pkg::LINE_W-1:0]   line_count, line_count_next;
  logic [vlws_pkg::ADDR_W-1:0]   read_index, read_index_next;
  logic                          record_mode, record_mode_next;
  logic                          fast_play, fast_play_next;
  logic                          ramp_mode, ramp_mode_next;
  logic [vlws_pkg::PERIOD_W-1:0] period_reg, period_reg_next;
  logic [vlws_pkg::DELAY_W-1:0]  delay_reg, delay_reg_next;
  logic [1:0]                    channel_reg, channel_reg_next;

  // result stage
  logic                          out_valid, out_valid_next;
  logic                          out_write, out_write_next;
  logic [vlws_pkg::DAC_W-1:0]    dac_hold;
  logic [vlws_pkg::DAC_W-1:0]    tbl_data;

  logic                          accept;
  vlws_pkg::table_req_t          tbl_req;

  // recording window and conversion arithmetic
  logic [vlws_pkg::LINE_W:0]     rec_off;
  logic                          rec_hit;
  logic [vlws_pkg::LINE_W:0]     period_raw;
  logic [6:0]                    pos_half;
  logic [15:0]                   ramp_wide;

  assign items.ready = !rst && (!out_valid || results.ready);
  assign accept      = items.valid && items.ready;

  // config writes: index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      record_start_line <= vlws_pkg::REC_START_RESET;
      rate_line         <= vlws_pkg::RATE_LINE_RESET;
      position_line     <= vlws_pkg::POS_LINE_RESET;
    end else if (cfg_we) begin
      unique case (vlws_pkg::cfg_index_t'(cfg_index))
        vlws_pkg::CFG_RECORD_START:  record_start_line <= cfg_data;
        vlws_pkg::CFG_RATE_LINE:     rate_line         <= cfg_data;
        vlws_pkg::CFG_POSITION_LINE: position_line     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rec_off    = {1'b0, line_count} - {1'b0, record_start_line};
  assign rec_hit    = (line_count >= record_start_line) &&
                      (rec_off < (vlws_pkg::LINE_W + 1)'(vlws_pkg::TABLE_DEPTH));
  assign period_raw = vlws_pkg::PERIOD_BASE - {1'b0, items.sample};
  assign pos_half   = items.sample[9:3];
  assign ramp_wide  = {8'd0, items.sample[9:2]};

  always_comb begin
    line_count_next  = line_count;
    read_index_next  = read_index;
    record_mode_next = record_mode;
    fast_play_next   = fast_play;
    ramp_mode_next   = ramp_mode;
    period_reg_next  = period_reg;
    delay_reg_next   = delay_reg;
    channel_reg_next = channel_reg;
    out_write_next   = 1'b0;
    tbl_req          = '0;
    tbl_req.wr_addr  = rec_off[vlws_pkg::ADDR_W-1:0];
    tbl_req.wr_data  = items.sample[9:2];
    tbl_req.rd_addr  = read_index;

    if (accept) begin
      unique case (vlws_pkg::cmd_t'(items.command))
        vlws_pkg::CMD_FIELD_START: begin
          line_count_next = '0;
          if (items.field_odd) begin
            if (items.rec_pin) begin
              record_mode_next = 1'b1;
              channel_reg_next = vlws_pkg::CHAN_VIDEO;
            end
          end else begin
            record_mode_next = 1'b0;
            channel_reg_next = vlws_pkg::CHAN_RATE;
          end
          fast_play_next = items.fast_pin;
          ramp_mode_next = !items.osc_pin;
        end
        vlws_pkg::CMD_LINE_SYNC: begin
          if (line_count != vlws_pkg::LINE_MAX) begin
            line_count_next = line_count + 1'b1;
          end
        end
        vlws_pkg::CMD_CONV_DONE: begin
          if (record_mode) begin
            tbl_req.wr_en = rec_hit;
          end else if (line_count == rate_line) begin
            if (ramp_mode) begin
              // control voltage picks the table entry to show directly
              tbl_req.rd_en   = 1'b1;
              tbl_req.rd_addr = ramp_wide[vlws_pkg::ADDR_W-1:0];
              out_write_next  = 1'b1;
            end else if (fast_play) begin
              period_reg_next = vlws_pkg::PERIOD_W'(period_raw);
            end else begin
              period_reg_next = {period_raw, 4'd0};
            end
            channel_reg_next = vlws_pkg::CHAN_POSITION;
          end else if (line_count == position_line) begin
            if (pos_half > 7'd1) begin
              delay_reg_next = vlws_pkg::DELAY_W'(pos_half) + vlws_pkg::DELAY_OFFSET;
            end
            channel_reg_next = vlws_pkg::CHAN_VIDEO;
          end
        end
        vlws_pkg::CMD_PLAY_TICK: begin
          if (!ramp_mode) begin
            tbl_req.rd_en   = 1'b1;
            read_index_next = read_index + 1'b1;
            out_write_next  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (results.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= '0;
      read_index  <= '0;
      record_mode <= 1'b0;
      fast_play   <= 1'b0;
      ramp_mode   <= 1'b0;
      period_reg  <= vlws_pkg::PERIOD_RESET;
      delay_reg   <= vlws_pkg::DELAY_RESET;
      channel_reg <= vlws_pkg::CHAN_VIDEO;
      out_valid   <= 1'b0;
      out_write   <= 1'b0;
      dac_hold    <= '0;
    end else begin
      line_count  <= line_count_next;
      read_index  <= read_index_next;
      record_mode <= record_mode_next;
      fast_play   <= fast_play_next;
      ramp_mode   <= ramp_mode_next;
      period_reg  <= period_reg_next;
      delay_reg   <= delay_reg_next;
      channel_reg <= channel_reg_next;
      out_valid   <= out_valid_next;
      if (accept) begin
        // converter keeps the value shown by the previous item
        out_write <= out_write_next;
        dac_hold  <= results.dac_value;
      end
    end
  end

  vlws_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .rd_data (tbl_data)
  );

  // settings only change on acceptance, so they are shown straight from state
  assign results.valid            = out_valid;
  assign results.dac_write        = out_write;
  assign results.dac_value        = out_write ? tbl_data : dac_hold;
  assign results.playback_period  = period_reg;
  assign results.playback_running = !ramp_mode;
  assign results.pulse_delay      = delay_reg;
  assign results.adc_channel      = channel_reg;

  // playback tick outside ramp mode always drives the converter
  `VLWS_ASSERT_NEXT(a_tick_writes, clk, rst,
    accept && items.command == vlws_pkg::CMD_PLAY_TICK && !ramp_mode,
    results.valid && results.dac_write)
  // line sync never drives the converter
  `VLWS_ASSERT_NEXT(a_sync_no_write, clk, rst,
    accept && items.command == vlws_pkg::CMD_LINE_SYNC,
    results.valid && !results.dac_write)
  // even field start selects the rate channel and latches the osc switch
  `VLWS_ASSERT_NEXT(a_even_field, clk, rst,
    accept && items.command == vlws_pkg::CMD_FIELD_START && !items.field_odd,
    results.adc_channel == vlws_pkg::CHAN_RATE &&
    results.playback_running == $past(items.osc_pin))

endmodule

// File: design/vlws_table.sv
// Wavetable memory with per-entry written bits; unwritten entries read the sine.
`timescale 1ns / 1ps
module vlws_table (
  input  logic                         clk,
  input  logic                         rst,
  input  vlws_pkg::table_req_t         req,
  output logic [vlws_pkg::DAC_W-1:0]   rd_data
);

  logic [vlws_pkg::DAC_W-1:0]       mem [vlws_pkg::TABLE_DEPTH];
  logic [vlws_pkg::TABLE_DEPTH-1:0] written;
  logic                             rd_written;
  logic [vlws_pkg::DAC_W-1:0]       mem_q;
  logic [vlws_pkg::DAC_W-1:0]       rom_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q      <= mem[req.rd_addr];
      rom_q      <= vlws_pkg::table_init(req.rd_addr);
      rd_written <= written[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_written ? mem_q : rom_q;

endmodule

// File: bench/vlws_sampler_checker.sv
// Checker for the wavetable sampler: predicts every result item and compares.
`timescale 1ns / 1ps
module vlws_sampler_checker
  import vlws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vlws_in_if                    items,
  vlws_out_if                   results,
  output int                    fail_count,
  output int                    outstanding
);

  typedef struct packed {
    logic                dac_write;
    logic [DAC_W-1:0]    dac_value;
    logic [PERIOD_W-1:0] period;
    logic                running;
    logic [DELAY_W-1:0]  delay;
    logic [1:0]          channel;
  } sampler_out_t;

  // Shadow of the sampler state
  logic [DAC_W-1:0]    wave [TABLE_DEPTH];
  logic [LINE_W-1:0]   line_no;
  logic [ADDR_W-1:0]   play_idx;
  logic                rec_on, fast_on, ramp_on;
  logic [PERIOD_W-1:0] period_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [1:0]          chan_q;
  logic [DAC_W-1:0]    dac_last;
  logic [LINE_W-1:0]   rec_start, rate_ln, pos_ln;

  sampler_out_t expected_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic restore_defaults();
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      wave[i] = SINE_ROM[(i * 256 / TABLE_DEPTH) % 256];
    end
    line_no   = '0;
    play_idx  = '0;
    rec_on    = 1'b0;
    fast_on   = 1'b0;
    ramp_on   = 1'b0;
    period_q  = PERIOD_RESET;
    delay_q   = DELAY_RESET;
    chan_q    = CHAN_VIDEO;
    dac_last  = '0;
    rec_start = REC_START_RESET;
    rate_ln   = RATE_LINE_RESET;
    pos_ln    = POS_LINE_RESET;
  endtask

  // Advance the shadow state by one event and return the result it yields.
  task automatic apply_event(input logic [1:0] cmd, input logic fo, input logic rp,
                             input logic fp, input logic op,
                             input logic [SAMPLE_W-1:0] smp, output sampler_out_t res);
    int          v;
    logic [15:0] p;
    logic        wr;
    wr = 1'b0;
    case (cmd)
      CMD_FIELD_START: begin
        line_no = '0;
        if (fo) begin
          if (rp) begin
            rec_on = 1'b1;
            chan_q = CHAN_VIDEO;
          end
        end else begin
          rec_on = 1'b0;
          chan_q = CHAN_RATE;
        end
        fast_on = fp;
        ramp_on = !op;
      end
      CMD_LINE_SYNC: begin
        if (line_no != LINE_MAX) line_no = line_no + 1'b1;
      end
      CMD_CONV_DONE: begin
        if (rec_on) begin
          if (int'(line_no) >= int'(rec_start) &&
              int'(line_no) < int'(rec_start) + TABLE_DEPTH) begin
            wave[(int'(line_no) - int'(rec_start)) % TABLE_DEPTH] = smp[9:2];
          end
        end else if (line_no == rate_ln) begin
          if (ramp_on) begin
            dac_last = wave[int'(smp[9:2]) % TABLE_DEPTH];
            wr = 1'b1;
          end else begin
            p = 16'(PERIOD_BASE) - 16'(smp);
            if (!fast_on) p = p * 16;
            period_q = p[PERIOD_W-1:0];
          end
          chan_q = CHAN_POSITION;
        end else if (line_no == pos_ln) begin
          v = int'(smp[9:2]) / 2;
          if (v > 1) delay_q = DELAY_W'(v) + DELAY_OFFSET;
          chan_q = CHAN_VIDEO;
        end
      end
      default: begin
        // playback tick; ignored in ramp mode
        if (!ramp_on) begin
          dac_last = wave[play_idx];
          play_idx = play_idx + 1'b1;
          wr = 1'b1;
        end
      end
    endcase
    res = '{wr, dac_last, period_q, !ramp_on, delay_q, chan_q};
  endtask

  task automatic report_mismatch(input string what, input sampler_out_t got,
                                 input sampler_out_t want);
    fail_count++;
    $display({"%0t %s: got wr=%0d dac=%02h per=%0d run=%0d dly=%0d ch=%0d",
              " / want wr=%0d dac=%02h per=%0d run=%0d dly=%0d ch=%0d"},
             $time, what, got.dac_write, got.dac_value, got.period, got.running,
             got.delay, got.channel, want.dac_write, want.dac_value, want.period,
             want.running, want.delay, want.channel);
  endtask

  always @(posedge clk) begin : watch
    sampler_out_t got;
    sampler_out_t want;
    if (rst) begin
      restore_defaults();
      expected_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        got = '{results.dac_write, results.dac_value, results.playback_period,
                results.playback_running, results.pulse_delay, results.adc_channel};
        if (expected_q.size() == 0) begin
          report_mismatch("result item with none expected", got, '0);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) report_mismatch("result item mismatch", got, want);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RECORD_START:  rec_start = cfg_data;
          CFG_RATE_LINE:     rate_ln   = cfg_data;
          CFG_POSITION_LINE: pos_ln    = cfg_data;
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        apply_event(items.command, items.field_odd, items.rec_pin, items.fast_pin,
                    items.osc_pin, items.sample, want);
        expected_q.push_back(want);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// File: bench/tb_video_line_wavetable_sampler_top.sv
// Testbench top: stimulus, settings writes, back-pressure and the verdict.
`timescale 1ns / 1ps
module tb_video_line_wavetable_sampler_top;
  import vlws_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_RECORD_START;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;

  // Stimulus-side copy of the line settings, only used to steer which lines
  // get conversions; prediction keeps its own copy in the checker.
  logic [LINE_W-1:0] rec_line = REC_START_RESET;
  logic [LINE_W-1:0] rate_at  = RATE_LINE_RESET;
  logic [LINE_W-1:0] pos_at   = POS_LINE_RESET;

  int sent = 0;     // items accepted so far
  bit hold_req = 0; // asks the result side for one long hold-off
  bit steady = 0;   // no gaps on the item side while set

  always #10 clk = ~clk;

  vlws_in_if  item_ch ();
  vlws_out_if result_ch ();

  video_line_wavetable_sampler_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (item_ch),
    .results   (result_ch)
  );

  vlws_sampler_checker sampler_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .items       (item_ch),
    .results     (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Item-side gap: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Sample values lean on the ends of the range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  // Offer one item and hold it until taken. valid stays high after
  // acceptance unless a gap follows, so back-to-back items never drop it.
  // pins = {field_odd, rec_pin, fast_pin, osc_pin}
  task automatic send_item(input cmd_t cmd, input logic [3:0] pins,
                           input logic [SAMPLE_W-1:0] smp);
    int gap;
    item_ch.valid     <= 1'b1;
    item_ch.command   <= cmd;
    item_ch.field_odd <= pins[3];
    item_ch.rec_pin   <= pins[2];
    item_ch.fast_pin  <= pins[1];
    item_ch.osc_pin   <= pins[0];
    item_ch.sample    <= smp;
    do @(posedge clk); while (!item_ch.ready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result item has arrived,
  // then idle so that the result register can settle.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Settings are only changed with the block idle.
  task automatic load_settings(input logic [LINE_W-1:0] rs, input logic [LINE_W-1:0] ra,
                               input logic [LINE_W-1:0] po);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RECORD_START;
    cfg_data  <= rs;
    @(posedge clk);
    cfg_index <= CFG_RATE_LINE;
    cfg_data  <= ra;
    @(posedge clk);
    cfg_index <= CFG_POSITION_LINE;
    cfg_data  <= po;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rec_line = rs;
    rate_at  = ra;
    pos_at   = po;
  endtask

  // One video field: field start, then line syncs with conversions and
  // playback ticks in between. Conversions are dense on the rate and
  // position lines and from dense_from on (the recording window).
  task automatic run_field(input logic [3:0] pins, input int nlines, input int dense_from,
                           input int sparse_pct, input int tick_pct, input int noise_pct);
    int ln;
    int pct;
    send_item(CMD_FIELD_START, pins, pick_sample());
    for (ln = 0; ln <= nlines; ln++) begin
      if (ln > 0) send_item(CMD_LINE_SYNC, 4'($urandom), pick_sample());
      if (ln == int'(rate_at) || ln == int'(pos_at)) pct = 85;
      else if (ln >= dense_from && ln < dense_from + TABLE_DEPTH + 4) pct = 90;
      else pct = sparse_pct;
      if ($urandom_range(0, 99) < pct) send_item(CMD_CONV_DONE, 4'($urandom), pick_sample());
      if ($urandom_range(0, 99) < tick_pct) begin
        send_item(CMD_PLAY_TICK, 4'($urandom), pick_sample());
      end
      // stray events that break the well-formed pattern
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(cmd_t'($urandom_range(0, 3)), 4'($urandom), pick_sample());
      end
    end
  endtask

  // Result side: random ready, with runs of solid ready and one long
  // hold-off on request while the item side keeps offering.
  initial begin : result_side
    int r;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          result_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (r < 70) begin
          result_ch.ready <= 1'b1;
          repeat ($urandom_range(40, 120)) @(posedge clk);
        end else if (r < 95) begin
          result_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_ch.ready <= 1'b0;
          repeat ($urandom_range(15, 30)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    int fld;
    logic [3:0] pins;
    logic [LINE_W-1:0] rs, ra, po;
    item_ch.valid     = 1'b0;
    item_ch.command   = CMD_FIELD_START;
    item_ch.field_odd = 1'b0;
    item_ch.rec_pin   = 1'b0;
    item_ch.fast_pin  = 1'b0;
    item_ch.osc_pin   = 1'b0;
    item_ch.sample    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out of reset: sine table plays back, period/delay at reset values.
    send_item(CMD_PLAY_TICK, 4'b0000, 10'd0);
    send_item(CMD_PLAY_TICK, 4'b1111, 10'd1023);
    // conversion on a line with no role: no change
    send_item(CMD_CONV_DONE, 4'b0000, 10'h155);

    // Small line numbers so every action is reachable in a few items.
    load_settings(10'd0, 10'd1, 10'd2);
    // record field: entries 0 and 1 get the extreme samples
    send_item(CMD_FIELD_START, 4'b1111, 10'd0);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd1023);
    send_item(CMD_LINE_SYNC, 4'b0000, 10'd0);
    send_item(CMD_CONV_DONE, 4'b1111, 10'd0);
    // even field, slow: sample 0 gives the longest period
    send_item(CMD_FIELD_START, 4'b0001, 10'd0);
    send_item(CMD_LINE_SYNC, 4'b0000, 10'd0);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd0);
    // position line: delay only moves once the halved value exceeds one
    send_item(CMD_LINE_SYNC, 4'b0000, 10'd0);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd7);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd12);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd1023);
    // fast mode: full-scale sample gives the shortest period
    send_item(CMD_FIELD_START, 4'b0011, 10'd0);
    send_item(CMD_LINE_SYNC, 4'b0000, 10'd0);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd1023);
    // ramp mode: ticks ignored, rate line drives the table entry directly
    send_item(CMD_FIELD_START, 4'b0100, 10'd0);
    send_item(CMD_PLAY_TICK, 4'b0000, 10'd0);
    send_item(CMD_LINE_SYNC, 4'b0000, 10'd0);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd1023);
    send_item(CMD_CONV_DONE, 4'b0000, 10'd0);
    // odd field without record switch keeps record mode and channel
    send_item(CMD_FIELD_START, 4'b1001, 10'd0);
    send_item(CMD_PLAY_TICK, 4'b0000, 10'd0);
    send_item(CMD_PLAY_TICK, 4'b0000, 10'd0);

    // Random phases. Phase 2 is one long record field recording from line
    // 767, then a short even field; the record field refills the whole
    // table and runs the line count into saturation.
    ph = 0;
    do begin
      if (ph == 2) begin
        load_settings(10'd767, 10'd1023, 10'd1023);
        run_field({2'b11, 1'($urandom), 1'b1}, 1030, 767, 3, 4, 0);
        run_field({1'b0, 1'($urandom), 1'($urandom), 1'b1}, 12, 767, 30, 25, 0);
      end else begin
        rs = LINE_W'($urandom_range(0, 12));
        ra = (ph == 0) ? 10'd0 : LINE_W'($urandom_range(0, 16));
        po = ($urandom_range(0, 3) == 0) ? ra : LINE_W'($urandom_range(1, 16));
        load_settings(rs, ra, po);
        for (fld = 0; fld < 4; fld++) begin
          steady = ($urandom_range(0, 3) == 0);
          // result side holds off while items keep coming
          if (ph == 1 && fld == 0) hold_req = 1;
          // item side waits for every outstanding result mid-phase
          if (ph == 3 && fld == 2) wait_idle();
          pins[3] = 1'($urandom);
          pins[2] = ($urandom_range(0, 99) < 60);
          pins[1] = 1'($urandom);
          pins[0] = ($urandom_range(0, 99) < 70);
          run_field(pins, $urandom_range(4, 28), int'(rec_line), 30, 25, 4);
        end
        steady = 0;
      end
      ph++;
    end while (sent < 1700 || ph < 4);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Hard limit, several times the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/vlws_pkg.sv
design/vlws_in_if.sv
design/vlws_out_if.sv
design/vlws_table.sv
design/video_line_wavetable_sampler_top.sv
bench/vlws_sampler_checker.sv
bench/tb_video_line_wavetable_sampler_top.sv
